[rtl/sfd_pkg.sv]
// Shared types and constants for the stereo feedback delay.
// No dependencies; imported by sfd_cfg, sfd_chan and the top level.
`default_nettype none

package sfd_pkg;

    localparam int DELAY_DEPTH = 131072;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);

    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 16;
    localparam int MIX_W    = 17;
    localparam int DELAY_W  = 17;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX      = 2'd2;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 17'd24000;
    localparam logic [GAIN_W-1:0]  FB_RESET    = 16'd22938;
    localparam logic [MIX_W-1:0]   MIX_RESET   = 17'd32768;
    localparam logic [MIX_W-1:0]   GAIN_ONE    = 17'd65536;

    // pipeline control handed to both channel datapaths
    typedef struct packed {
        logic accept;   // word taken this edge, memory read issued
        logic advance;  // whole pipeline moves this edge
        logic s1_fwd;   // stage 1 takes the forwarded write data
        logic s1_zero;  // stage 1 entry never written since reset
    } sfd_ctrl_t;

endpackage

`default_nettype wire

[rtl/sfd_ram.sv]
// Generic simple dual-port RAM, one write and one registered read per cycle.
// Read returns the old contents when read and write hit the same address.
`default_nettype none

module sfd_ram #(
    parameter int DATA_W = 24,
    parameter int ADDR_W = 17
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/sfd_cfg.sv]
// Configuration registers: delay length, feedback gain, wet mix.
// Depends on sfd_pkg. Mix is clamped to unity on the way out.
`default_nettype none

module sfd_cfg
    import sfd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output logic      [DELAY_W-1:0]   delay_samples,
    output logic      [GAIN_W-1:0]    feedback_gain,
    output logic      [MIX_W-1:0]     wet_mix
);

    logic [DELAY_W-1:0] delay_reg;
    logic [GAIN_W-1:0]  fb_reg;
    logic [MIX_W-1:0]   mix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RESET;
            fb_reg    <= FB_RESET;
            mix_reg   <= MIX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DELAY:    delay_reg <= cfg_data[DELAY_W-1:0];
                CFG_FEEDBACK: fb_reg    <= cfg_data[GAIN_W-1:0];
                CFG_MIX:      mix_reg   <= cfg_data[MIX_W-1:0];
                default:      ;
            endcase
        end
    end

    assign delay_samples = delay_reg;
    assign feedback_gain = fb_reg;
    assign wet_mix       = (mix_reg > GAIN_ONE) ? GAIN_ONE : mix_reg;

endmodule

`default_nettype wire

[rtl/sfd_chan.sv]
// One channel datapath: multiply stage, feedback/mix stage, output register.
// Depends on sfd_pkg; delay memory sits outside, in the top level.
`default_nettype none

module sfd_chan
    import sfd_pkg::*;
(
    input  wire logic                       clk,
    input  wire sfd_ctrl_t                  ctrl,
    input  wire logic signed [SAMPLE_W-1:0] dry_in,
    input  wire logic signed [SAMPLE_W-1:0] rd_data,
    input  wire logic        [GAIN_W-1:0]   feedback_gain,
    input  wire logic        [MIX_W-1:0]    wet_mix,
    output logic signed      [SAMPLE_W-1:0] wr_data,
    output logic signed      [SAMPLE_W-1:0] sample_out
);

    localparam int FBP_W = SAMPLE_W + GAIN_W + 1;
    localparam int MXP_W = SAMPLE_W + MIX_W + 1;

    logic signed [SAMPLE_W-1:0] dry_s1_reg;
    logic signed [SAMPLE_W-1:0] fwd_data_reg;
    logic signed [SAMPLE_W-1:0] dry_s2_reg;
    logic signed [FBP_W-1:0]    fbp_reg;
    logic signed [MXP_W-1:0]    wetp_reg;
    logic signed [MXP_W-1:0]    dryp_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    logic signed [SAMPLE_W-1:0] delayed;
    logic        [MIX_W:0]      inv_mix;
    logic signed [FBP_W-1:0]    fbp_next;
    logic signed [MXP_W-1:0]    wetp_next;
    logic signed [MXP_W-1:0]    dryp_next;
    logic signed [FBP_W-17:0]   fb_term;
    logic signed [SAMPLE_W+1:0] fb_sum;
    logic signed [MXP_W:0]      mix_sum;

    // stage 1: pick delayed sample, form the three products
    always_comb
    begin
        if (ctrl.s1_zero)
        begin
            delayed = '0;
        end
        else if (ctrl.s1_fwd)
        begin
            delayed = fwd_data_reg;
        end
        else
        begin
            delayed = rd_data;
        end
        inv_mix   = {1'b0, GAIN_ONE} - {1'b0, wet_mix};
        fbp_next  = delayed * $signed({1'b0, feedback_gain});
        wetp_next = delayed * $signed({1'b0, wet_mix});
        dryp_next = dry_s1_reg * $signed(inv_mix);
    end

    // stage 2: feedback sum with saturation, mix with floor shift
    always_comb
    begin
        fb_term = fbp_reg[FBP_W-1:16];
        fb_sum  = {{2{dry_s2_reg[SAMPLE_W-1]}}, dry_s2_reg}
                + {fb_term[FBP_W-17], fb_term};
        if ((fb_sum[SAMPLE_W+1:SAMPLE_W-1] == 3'b000)
            || (fb_sum[SAMPLE_W+1:SAMPLE_W-1] == 3'b111))
        begin
            wr_data = fb_sum[SAMPLE_W-1:0];
        end
        else if (fb_sum[SAMPLE_W+1])
        begin
            wr_data = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            wr_data = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        // convex mix of two samples always fits, no clamp needed
        mix_sum = {dryp_reg[MXP_W-1], dryp_reg} + {wetp_reg[MXP_W-1], wetp_reg};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            dry_s1_reg   <= dry_in;
            fwd_data_reg <= wr_data;
        end
        if (ctrl.advance)
        begin
            dry_s2_reg <= dry_s1_reg;
            fbp_reg    <= fbp_next;
            wetp_reg   <= wetp_next;
            dryp_reg   <= dryp_next;
            out_reg    <= mix_sum[SAMPLE_W+15:16];
        end
    end

    assign sample_out = out_reg;

endmodule

`default_nettype wire

[rtl/stereo_feedback_delay.sv]
// Stereo feedback echo: top level with delay memories and pipeline control.
// Depends on sfd_pkg, sfd_ram, sfd_cfg and sfd_chan.
//
// Usage:
//   s_axis takes one stereo word per cycle: left_in in tdata[23:0],
//   right_in in tdata[47:24]. m_axis returns one mixed word per input word,
//   same packing. Config writes (cfg_we/cfg_index/cfg_data) go in while
//   the block is idle; index 0 delay, 1 feedback gain, 2 wet mix.
// Throughput: one word per cycle while m_axis takes them. The one exception
//   is a delay of one sample (mod depth): the read then hits the entry the
//   word before is still computing, and tready drops for one cycle.
// Pipeline: accept issues the memory read; stage 1 multiplies; stage 2
//   saturates the feedback sum, writes it to memory and forms the mix;
//   the output register holds the result. A write that lands on the edge
//   of a read to the same entry is forwarded into stage 1.
// Reset: pointer at zero, registers at their defaults. Memories are not
//   swept; a fill flag marks entries not yet written, which read as zero.
//   No clearing pass, so the block is ready right after reset.
// Stall: when m_axis_tready is low with a word waiting, the whole
//   pipeline holds and s_axis_tready drops.
`default_nettype none

module stereo_feedback_delay
    import sfd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // config write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    // input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [47:0]          s_axis_tdata,  // left_in [23:0], right_in [47:24]
    // output stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [47:0]          m_axis_tdata   // left_out [23:0], right_out [47:24]
);

    logic [DELAY_W-1:0] delay_samples;
    logic [GAIN_W-1:0]  feedback_gain;
    logic [MIX_W-1:0]   wet_mix;

    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic              wrapped_reg;
    logic              s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic [ADDR_W-1:0] s1_wp_reg, s2_wp_reg;
    logic              s1_fwd_reg, s1_zero_reg;

    logic              advance;
    logic              hazard;
    logic              accept;
    logic              ram_we;
    logic [ADDR_W-1:0] rd_addr;
    logic              fwd_hit;
    logic              rd_unwritten;
    sfd_ctrl_t         ctrl;

    logic signed [SAMPLE_W-1:0] l_rd, r_rd, l_wr, r_wr, l_out, r_out;

    sfd_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .delay_samples (delay_samples),
        .feedback_gain (feedback_gain),
        .wet_mix       (wet_mix)
    );

    // read address trails the write pointer by the delay, wrapping mod depth
    assign rd_addr = wp_reg - ADDR_W'(delay_samples);

    // before the first wrap only entries below the pointer hold data
    assign rd_unwritten = !wrapped_reg && !(rd_addr < wp_reg);

    assign advance = !out_valid_reg || m_axis_tready;
    // stage 1 word has not produced its write data yet: hold s_axis_tready low
    assign hazard  = s1_valid_reg && (s1_wp_reg == rd_addr);
    assign s_axis_tready = advance && !hazard;
    assign accept  = s_axis_tvalid && s_axis_tready;

    // stage 2 writes on every advance that holds a valid word; catch it if it hits our read
    assign ram_we  = advance && s2_valid_reg;
    assign fwd_hit = s2_valid_reg && (s2_wp_reg == rd_addr);
    assign wp_next = wp_reg + ADDR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wp_reg <= wp_next;
                if (wp_reg == '1)
                begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (advance)
            begin
                s1_valid_reg  <= accept;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_wp_reg   <= wp_reg;
            s1_fwd_reg  <= fwd_hit;
            s1_zero_reg <= rd_unwritten;
        end
        if (advance)
        begin
            s2_wp_reg <= s1_wp_reg;
        end
    end

    assign ctrl.accept  = accept;
    assign ctrl.advance = advance;
    assign ctrl.s1_fwd  = s1_fwd_reg;
    assign ctrl.s1_zero = s1_zero_reg;

    sfd_ram #(
        .DATA_W (SAMPLE_W),
        .ADDR_W (ADDR_W)
    ) u_ram_l (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s2_wp_reg),
        .wdata (l_wr),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (l_rd)
    );

    sfd_ram #(
        .DATA_W (SAMPLE_W),
        .ADDR_W (ADDR_W)
    ) u_ram_r (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s2_wp_reg),
        .wdata (r_wr),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (r_rd)
    );

    sfd_chan u_chan_l (
        .clk           (clk),
        .ctrl          (ctrl),
        .dry_in        (s_axis_tdata[23:0]),
        .rd_data       (l_rd),
        .feedback_gain (feedback_gain),
        .wet_mix       (wet_mix),
        .wr_data       (l_wr),
        .sample_out    (l_out)
    );

    sfd_chan u_chan_r (
        .clk           (clk),
        .ctrl          (ctrl),
        .dry_in        (s_axis_tdata[47:24]),
        .rd_data       (r_rd),
        .feedback_gain (feedback_gain),
        .wet_mix       (wet_mix),
        .wr_data       (r_wr),
        .sample_out    (r_out)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {r_out, l_out};

    // pointer moves by exactly one per accepted word
    a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (wp_reg == $past(wp_next)))
        else $error("write pointer did not step on accept");

    // words in flight carry consecutive pointers
    a_s1_s2_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg) |-> (s1_wp_reg == s2_wp_reg + ADDR_W'(1)))
        else $error("stage 1 and stage 2 pointers not consecutive");

    a_s1_wp: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (wp_reg == s1_wp_reg + ADDR_W'(1)))
        else $error("stage 1 pointer out of step with write pointer");

    // fill flag is sticky until reset
    a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(wrapped_reg))
        else $error("fill flag cleared without reset");

endmodule

`default_nettype wire
